[design/onewire_temperature_reader_unit_macros.svh]
// assertion macros for the one-wire temperature reader
// used by the top level; expects clk and arst_n in scope
`ifndef ONEWIRE_TEMPERATURE_READER_UNIT_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OWTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define OWTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/owtr_pkg.sv]
// shared types and constants of the one-wire temperature reader
// no dependencies
`timescale 1ns / 1ps

package owtr_pkg;

	// sequencer phases
	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_PRE_HIGH  = 4'd1;
	localparam logic [3:0] PH_RESET_LOW = 4'd2;
	localparam logic [3:0] PH_PRES_WAIT = 4'd3;
	localparam logic [3:0] PH_POST_PRES = 4'd4;
	localparam logic [3:0] PH_W_HIGH    = 4'd5;
	localparam logic [3:0] PH_W_LOW     = 4'd6;
	localparam logic [3:0] PH_W_SLOT    = 4'd7;
	localparam logic [3:0] PH_R_LOW     = 4'd8;
	localparam logic [3:0] PH_R_HIGH    = 4'd9;
	localparam logic [3:0] PH_R_SLOT    = 4'd10;
	localparam logic [3:0] PH_FINAL     = 4'd11;

	// steps of a read sequence
	localparam logic [2:0] STEP_RESET1   = 3'd0;
	localparam logic [2:0] STEP_SKIP1    = 3'd1;
	localparam logic [2:0] STEP_CONVERT  = 3'd2;
	localparam logic [2:0] STEP_RESET2   = 3'd3;
	localparam logic [2:0] STEP_SKIP2    = 3'd4;
	localparam logic [2:0] STEP_READ_PAD = 3'd5;
	localparam logic [2:0] STEP_RD_LSB   = 3'd6;
	localparam logic [2:0] STEP_RD_MSB   = 3'd7;

	// bus commands
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POST_PRES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 3'd5;

	// configuration reset values
	localparam logic [7:0] RST_PRE_HIGH  = 8'd8;
	localparam logic [7:0] RST_RESET_LOW = 8'd90;
	localparam logic [7:0] RST_PRES_WAIT = 8'd8;
	localparam logic [7:0] RST_POST_PRES = 8'd10;
	localparam logic [7:0] RST_SLOT      = 8'd10;
	localparam logic [7:0] RST_PULSE     = 8'd1;

	typedef struct packed {
		logic [7:0] pre_high;
		logic [7:0] reset_low;
		logic [7:0] pres_wait;
		logic [7:0] post_pres;
		logic [7:0] slot;
		logic [7:0] pulse;
	} cfg_t;

	typedef struct packed {
		logic       line_low;
		logic       busy;
		logic       done;
		logic       absent;
		logic [7:0] lsb;
		logic [7:0] msb;
	} res_t;

endpackage

[design/owtr_seq.sv]
// bus sequencer of the one-wire temperature reader: state and one tick of work
// depends on owtr_pkg
`timescale 1ns / 1ps

module owtr_seq import owtr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic start_req,
	input  logic bus_level,
	input  cfg_t cfg,
	output res_t res
);

	logic [3:0] phase_q,  phase_d;
	logic [7:0] tick_q,   tick_d;
	logic [2:0] bit_q,    bit_d;
	logic [2:0] step_q,   step_d;
	logic [7:0] shift_q,  shift_d;
	logic [7:0] low_q,    low_d;
	logic [7:0] high_q,   high_d;
	logic       absent_q, absent_d;

	logic       begin_en;
	logic [2:0] begin_sel;
	logic       last;
	logic [7:0] len_m1;
	logic       drive;
	logic       done;

	// a zero length counts as one tick
	function automatic logic [7:0] last_tick(input logic [7:0] n);
		return (n == 8'd0) ? 8'd0 : n - 8'd1;
	endfunction

	always_comb begin
		case (phase_q)
			PH_PRE_HIGH:  len_m1 = last_tick(cfg.pre_high);
			PH_RESET_LOW: len_m1 = last_tick(cfg.reset_low);
			PH_PRES_WAIT: len_m1 = last_tick(cfg.pres_wait);
			PH_POST_PRES: len_m1 = last_tick(cfg.post_pres);
			PH_W_SLOT,
			PH_R_SLOT,
			PH_FINAL:     len_m1 = last_tick(cfg.slot);
			default:      len_m1 = last_tick(cfg.pulse);
		endcase
		last = (tick_q >= len_m1);
	end

	always_comb begin
		phase_d   = phase_q;
		tick_d    = last ? 8'd0 : tick_q + 8'd1;
		bit_d     = bit_q;
		step_d    = step_q;
		shift_d   = shift_q;
		low_d     = low_q;
		high_d    = high_q;
		absent_d  = absent_q;
		begin_en  = 1'b0;
		begin_sel = step_q + 3'd1;
		drive     = 1'b0;
		done      = 1'b0;

		case (phase_q)
			PH_PRE_HIGH: begin
				if (last) phase_d = PH_RESET_LOW;
			end
			PH_RESET_LOW: begin
				drive = 1'b1;
				if (last) phase_d = PH_PRES_WAIT;
			end
			PH_PRES_WAIT: begin
				if (last) begin
					if (step_q == STEP_RESET1) absent_d = bus_level;
					phase_d = PH_POST_PRES;
				end
			end
			PH_POST_PRES: begin
				if (last) begin
					if (step_q == STEP_RESET1 && absent_q) begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						begin_en = 1'b1;
					end
				end
			end
			PH_W_HIGH: begin
				if (last) phase_d = PH_W_LOW;
			end
			PH_W_LOW: begin
				drive = 1'b1;
				if (last) phase_d = PH_W_SLOT;
			end
			PH_W_SLOT: begin
				drive = ~shift_q[0];
				if (last) begin
					shift_d = {1'b0, shift_q[7:1]};
					if (bit_q == 3'd7) begin
						begin_en = 1'b1;
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_W_HIGH;
					end
				end
			end
			PH_R_LOW: begin
				drive = 1'b1;
				if (last) phase_d = PH_R_HIGH;
			end
			PH_R_HIGH: begin
				if (last) begin
					if (bus_level) shift_d[bit_q] = 1'b1;
					phase_d = PH_R_SLOT;
				end
			end
			PH_R_SLOT: begin
				if (last) begin
					if (bit_q == 3'd7) begin
						if (step_q == STEP_RD_LSB) begin
							low_d     = shift_q;
							begin_en  = 1'b1;
							begin_sel = STEP_RD_MSB;
						end else begin
							high_d  = shift_q;
							phase_d = PH_FINAL;
						end
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_R_LOW;
					end
				end
			end
			PH_FINAL: begin
				if (last) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = 8'd0;
				if (start_req) begin
					absent_d  = 1'b0;
					begin_en  = 1'b1;
					begin_sel = STEP_RESET1;
				end
			end
		endcase

		if (begin_en) begin
			step_d = begin_sel;
			bit_d  = 3'd0;
			tick_d = 8'd0;
			case (begin_sel) inside
				STEP_RESET1, STEP_RESET2: phase_d = PH_PRE_HIGH;
				STEP_SKIP1, STEP_SKIP2: begin
					shift_d = CMD_SKIP_ROM;
					phase_d = PH_W_HIGH;
				end
				STEP_CONVERT: begin
					shift_d = CMD_CONVERT;
					phase_d = PH_W_HIGH;
				end
				STEP_READ_PAD: begin
					shift_d = CMD_READ_PAD;
					phase_d = PH_W_HIGH;
				end
				default: begin
					shift_d = 8'd0;
					phase_d = PH_R_LOW;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= 8'd0;
			bit_q    <= 3'd0;
			step_q   <= 3'd0;
			shift_q  <= 8'd0;
			low_q    <= 8'd0;
			high_q   <= 8'd0;
			absent_q <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bit_q    <= bit_d;
			step_q   <= step_d;
			shift_q  <= shift_d;
			low_q    <= low_d;
			high_q   <= high_d;
			absent_q <= absent_d;
		end
	end

	assign res.line_low = drive;
	assign res.busy     = (phase_q != PH_IDLE);
	assign res.done     = done;
	assign res.absent   = absent_d;
	assign res.lsb      = low_d;
	assign res.msb      = high_d;

endmodule

[design/onewire_temperature_reader_unit.sv]
// top level of the one-wire temperature reader: config registers and output skid
// depends on owtr_pkg, owtr_seq and onewire_temperature_reader_unit_macros.svh
`timescale 1ns / 1ps
`include "onewire_temperature_reader_unit_macros.svh"

// One-wire bus master that runs a two-byte temperature read. Every input
// transaction is one tick of the bus timebase (start request plus sampled line
// level) and yields exactly one output transaction with the line drive and
// status for that tick. A sequence is: reset with presence check, skip-ROM and
// convert, a second reset, skip-ROM and read-scratchpad, two bytes read LSB
// first, then a recovery slot; an absent device ends it at the end of the
// post-presence wait that follows the first presence sample, with done and
// device_absent set. The block takes one tick per clock cycle while in_stall
// is low: the sequencer state steps once per accepted tick and its result is
// registered in the output register. A one-entry skid buffer behind it holds a
// result while the output is stalled, so the input keeps flowing for one more
// tick; in_stall comes straight from that buffer's full flag.
// Configuration registers may be written only while no sequence is running.

module onewire_temperature_reader_unit import owtr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// tick input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_req,
	input  logic                 bus_level,
	// status output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 device_absent,
	output logic [7:0]           temp_lsb,
	output logic [7:0]           temp_msb,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t cfg_q;
	res_t res;
	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic accept;
	logic out_free;

	// a tick is taken whenever the skid slot is empty
	assign accept   = in_valid && !skid_valid_q;
	assign in_stall = skid_valid_q;
	// output register can take new data this cycle
	assign out_free = !out_valid_q || !out_stall;

	// configuration registers, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_high  <= RST_PRE_HIGH;
			cfg_q.reset_low <= RST_RESET_LOW;
			cfg_q.pres_wait <= RST_PRES_WAIT;
			cfg_q.post_pres <= RST_POST_PRES;
			cfg_q.slot      <= RST_SLOT;
			cfg_q.pulse     <= RST_PULSE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRE_HIGH:  cfg_q.pre_high  <= cfg_data;
				REG_RESET_LOW: cfg_q.reset_low <= cfg_data;
				REG_PRES_WAIT: cfg_q.pres_wait <= cfg_data;
				REG_POST_PRES: cfg_q.post_pres <= cfg_data;
				REG_SLOT:      cfg_q.slot      <= cfg_data;
				REG_PULSE:     cfg_q.pulse     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer steps once per accepted tick
	owtr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (accept),
		.start_req (start_req),
		.bus_level (bus_level),
		.cfg       (cfg_q),
		.res       (res)
	);

	// output register and skid slot, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// skid drains first; no tick is taken while it is full
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_low      = out_q.line_low;
	assign busy_res      = out_q.busy;
	assign done_res      = out_q.done;
	assign device_absent = out_q.absent;
	assign temp_lsb      = out_q.lsb;
	assign temp_msb      = out_q.msb;

	// skid slot only fills behind a held output
	`OWTR_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	// skid is empty in the cycle after the output moves
	`OWTR_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall, !skid_valid_q, "skid did not drain")
	// line is only pulled low during a sequence
	`OWTR_ASSERT_NOW(a_drive_when_busy, out_valid_q && out_q.line_low, out_q.busy, "line driven while idle")
	// a sequence ends on a busy tick with the line released
	`OWTR_ASSERT_NOW(a_done_shape, out_valid_q && out_q.done, out_q.busy && !out_q.line_low, "bad done tick")

endmodule
